FILE: rtl/bftr_pkg.sv
// Shared constants, codes and types for the bitmap font text renderer.
package bftr_pkg;

   // Default geometry handed to the top-level parameters
   localparam int unsigned SCREEN_WIDTH_DEF  = 800;
   localparam int unsigned SCREEN_HEIGHT_DEF = 480;
   localparam int unsigned GLYPH_ROWS_DEF    = 16;
   localparam int unsigned GLYPH_COUNT_DEF   = 256;

   // Fixed field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned POS_W    = 13;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned YROW_W   = 14;
   localparam int unsigned COLOR_W  = 16;
   localparam int unsigned STRIDE_W = 4;
   localparam int unsigned GLYPH_W  = 8;

   localparam int unsigned STORE_DEPTH = 4096;
   localparam int unsigned REQ_DATA_W  = 56;
   localparam int unsigned RSP_DATA_W  = 56;

   localparam logic [COLOR_W-1:0] INK_RESET = 16'hFFFF;
   localparam logic [POS_W-1:0]   COL_MAX   = 13'sd4095;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_CURSOR = 2'd1,
      CMD_DRAW   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DRAW = 2'b10
   } state_type;

endpackage

FILE: rtl/bitmap_font_text_renderer_core.sv
// Top level of the bitmap font text renderer: font store, cursor, row sequencer.
//
// Text renderer for an 8-pixel-wide bitmap font of up to 16 rows per glyph.
// Each request transaction carries a command in req_tuser: load writes one
// byte into the 4096-byte font store (address = glyph code * 16 + row), set
// cursor places the signed text cursor, and draw emits GLYPH_ROWS response
// transactions for a nonzero character code, one per glyph row, with tlast on
// the final row; the cursor then moves right by 8 columns, saturating at 4095.
// Pixels off the screen are cleared from the mask. Character code 0 and the
// unused command code emit nothing. Load and set cursor leave req_tready high.
// A draw holds req_tready low from its acceptance until its final row is
// emitted: the single font store read port yields one glyph row per cycle
// through a registered read while rsp_tready stays high, and a stalled
// response holds the sequence. Font store contents are undefined until
// loaded; there is no clearing pass. ink_color resets to white. The user must
// write it via csr_ only while the block is idle; the block does not enforce it.
module bitmap_font_text_renderer_core #(
   parameter int unsigned SCREEN_WIDTH  = bftr_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT = bftr_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned GLYPH_ROWS    = bftr_pkg::GLYPH_ROWS_DEF,
   parameter int unsigned GLYPH_COUNT   = bftr_pkg::GLYPH_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // font_index[11:0], font_byte[19:12], start_col[32:20], start_row[45:33],
   // char_code[53:46], zero fill [55:54]
   input  logic [bftr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[1:0]
   input  logic [bftr_pkg::CMD_W-1:0]         req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_row[13:0], pixel_col[26:14], pixel_mask[34:27], pixel_color[50:35],
   // zero fill [55:51]
   output logic [bftr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // configuration: ink_color
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bftr_pkg::COLOR_W-1:0]       csr_data
);
   import bftr_pkg::*;

   localparam int unsigned ISSUE_W = $clog2(GLYPH_ROWS + 1);
   localparam int unsigned ROW_W   = $clog2(GLYPH_ROWS);
   localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(GLYPH_ROWS - 1);
   localparam logic [ISSUE_W-1:0] ROW_TOTAL  = ISSUE_W'(GLYPH_ROWS);
   localparam logic [CODE_W:0]    GLYPH_CNT  = (CODE_W+1)'(GLYPH_COUNT);
   localparam logic [YROW_W-1:0]  SCR_W      = YROW_W'(SCREEN_WIDTH);
   localparam logic [YROW_W-1:0]  SCR_H      = YROW_W'(SCREEN_HEIGHT);

   // Unpacked request fields
   logic [INDEX_W-1:0] font_index;
   logic [BYTE_W-1:0]  font_byte;
   logic [POS_W-1:0]   start_col;
   logic [POS_W-1:0]   start_row;
   logic [CODE_W-1:0]  char_code;
   cmd_type            command;

   assign font_index = req_tdata[11:0];
   assign font_byte  = req_tdata[19:12];
   assign start_col  = req_tdata[32:20];
   assign start_row  = req_tdata[45:33];
   assign char_code  = req_tdata[53:46];
   assign command    = cmd_type'(req_tuser);

   // Sequencer and cursor state
   state_type           state_ff, state_in;
   logic [POS_W-1:0]    cursor_col_ff, cursor_col_in;
   logic [POS_W-1:0]    cursor_row_ff, cursor_row_in;
   logic [COLOR_W-1:0]  ink_ff;
   logic [GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [7:0]          col_vis_ff, col_vis_in;
   logic [ISSUE_W-1:0]  issue_row_ff, issue_row_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ROW_W-1:0]    rd_row_ff, rd_row_in;
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_accept;
   logic                advance;
   logic                rd_enable;
   logic                mem_write;
   logic [INDEX_W-1:0]  rd_addr;
   logic                last_emit;
   logic [CODE_W:0]     code_wide;
   logic [YROW_W-1:0]   row_y;
   logic                row_vis;
   logic [BYTE_W-1:0]   row_mask;
   logic [YROW_W-1:0]   col_next;

   logic [BYTE_W-1:0]   font_mem [STORE_DEPTH];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Pipeline moves only when the response register can take a new row
   assign advance   = (state_ff == S_DRAW) && (!rsp_valid_ff || rsp_tready);
   assign rd_enable = advance && (issue_row_ff < ROW_TOTAL);
   assign rd_addr   = {glyph_ff, STRIDE_W'(issue_row_ff)};
   assign mem_write = req_accept && (command == CMD_LOAD);
   assign last_emit = advance && rd_valid_ff && (rd_row_ff == LAST_ROW);

   // Glyph code widened for the fold into the glyph set; one subtraction covers codes below 2 * GLYPH_COUNT
   assign code_wide = {1'b0, char_code};

   // Row position and row visibility for the row leaving the read stage
   assign row_y   = {cursor_row_ff[POS_W-1], cursor_row_ff} + YROW_W'(rd_row_ff);
   assign row_vis = !row_y[YROW_W-1] && ($signed(row_y) < $signed(SCR_H));
   assign row_mask = row_vis ? (rd_data_ff & col_vis_ff) : '0;

   assign col_next = {cursor_col_ff[POS_W-1], cursor_col_ff} + YROW_W'(8);

   // Column visibility of the eight glyph pixels, bit 7 leftmost
   always_comb begin
      logic [YROW_W-1:0] x;
      x = '0;
      col_vis_in = '0;
      for (int c = 0; c < 8; c++) begin
         x = {cursor_col_ff[POS_W-1], cursor_col_ff} + YROW_W'(c);
         col_vis_in[7-c] = !x[YROW_W-1] && ($signed(x) < $signed(SCR_W));
      end
   end

   always_comb begin
      state_in      = state_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      glyph_in      = glyph_ff;
      issue_row_in  = issue_row_ff;
      rd_valid_in   = rd_valid_ff;
      rd_row_in     = rd_row_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (command)
                  CMD_CURSOR: begin
                     cursor_col_in = start_col;
                     cursor_row_in = start_row;
                  end
                  CMD_DRAW: begin
                     if (char_code != '0) begin
                        state_in     = S_DRAW;
                        issue_row_in = '0;
                        rd_valid_in  = 1'b0;
                        glyph_in     = (code_wide >= GLYPH_CNT) ?
                                       GLYPH_W'(code_wide - GLYPH_CNT) : char_code;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAW: begin
            if (advance) begin
               // Read stage: fetch the next glyph row, or drain
               if (rd_enable) begin
                  rd_valid_in  = 1'b1;
                  rd_row_in    = ROW_W'(issue_row_ff);
                  issue_row_in = issue_row_ff + ISSUE_W'(1);
               end else begin
                  rd_valid_in = 1'b0;
               end
               // Emit the row held in the read stage
               if (rd_valid_ff) begin
                  rsp_data_in = RSP_DATA_W'({ink_ff, row_mask, cursor_col_ff, row_y});
                  rsp_last_in = (rd_row_ff == LAST_ROW);
               end
               if (last_emit) begin
                  state_in      = S_IDLE;
                  cursor_col_in = ($signed(col_next) > $signed({1'b0, COL_MAX})) ?
                                  COL_MAX : col_next[POS_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Output register: load a row on advance, drop once taken
      if (advance && rd_valid_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         ink_ff        <= INK_RESET;
         issue_row_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         issue_row_ff  <= issue_row_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ink_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      rd_row_ff   <= rd_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_accept && (command == CMD_DRAW)) begin
         col_vis_ff <= col_vis_in;
      end
   end

   // Font store: one write port for loads, one registered read port for draws
   always_ff @(posedge clock) begin
      if (mem_write) begin
         font_mem[font_index] <= font_byte;
      end
      if (rd_enable) begin
         rd_data_ff <= font_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Read stage holds a row only while a glyph is being drawn
   a_rd_in_draw : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_DRAW))
      else $error("read stage valid outside a draw");

   // Issue counter never runs past the glyph height
   a_issue_bound : assert property (@(posedge clock) disable iff (reset)
      issue_row_ff <= ROW_TOTAL)
      else $error("row issue counter overran");

   // Emitting the final row ends the draw and marks tlast
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      last_emit |=> (state_ff == S_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("final row did not close the draw");

   // Cursor column moves only on set cursor or at the end of a draw
   a_cursor_move : assert property (@(posedge clock) disable iff (reset)
      !$stable(cursor_col_ff) |->
         $past(last_emit) || $past(req_accept && (command == CMD_CURSOR)))
      else $error("cursor column changed unexpectedly");

endmodule
